>>> rtl/kwm_pkg.sv
// Shared definitions for the k-way sorted merge core.
// Holds the sizing constants, operation and status codes, the controller state type
// and the structures passed along the row of list cells. Depends on nothing.
package kwm_pkg;

   localparam int LISTS      = 8;
   localparam int LIST_DEPTH = 16;
   localparam int DATA_W     = 32;

   localparam int LIST_IDX_W = (LISTS > 1) ? $clog2(LISTS) : 1;
   localparam int PTR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int SCAN_W     = (LISTS > 1) ? $clog2(LISTS) : 1;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP
   } state_type;

   // Running minimum handed from one cell to the next.
   typedef struct packed {
      logic                     found;
      logic [LIST_IDX_W-1:0]    idx;
      logic signed [DATA_W-1:0] val;
   } carry_type;

   // Occupancy flags that each cell reports to the controller.
   typedef struct packed {
      logic nonempty;
      logic full;
   } cell_status_type;

   localparam carry_type CARRY_NONE = '{found: 1'b0, idx: '0, val: '0};

endpackage

>>> rtl/kwm_cell.sv
// One list cell of the merge core: a ring queue with its head pointer and count.
// It also folds its head value into the running minimum passed along the row.
// Depends on kwm_pkg.
module kwm_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [kwm_pkg::LIST_IDX_W-1:0]   cell_idx,
   input  logic                             wr_en,
   input  logic [kwm_pkg::DATA_W-1:0]       wr_data,
   input  logic                             pop_en,
   input  kwm_pkg::carry_type               carry_in,
   output kwm_pkg::carry_type               carry_out,
   output kwm_pkg::cell_status_type         cell_status
);
   import kwm_pkg::*;

   localparam int SUM_W = PTR_W + 1;

   logic [DATA_W-1:0] list_mem_ff [LIST_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  head_ptr_ff, head_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   carry_type         carry_ff, carry_in_next;
   logic [SUM_W-1:0]  tail_sum;
   logic [SUM_W-1:0]  tail_wrap;
   logic [PTR_W-1:0]  tail_ptr;
   logic              nonempty;
   logic              take_own;

   assign nonempty  = (count_ff != '0);
   assign tail_sum  = SUM_W'(head_ptr_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(LIST_DEPTH)) ? tail_sum - SUM_W'(LIST_DEPTH)
                                                       : tail_sum;
   assign tail_ptr  = tail_wrap[PTR_W-1:0];

   always_comb begin
      head_ptr_in = head_ptr_ff;
      count_in    = count_ff;
      if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_en) begin
         count_in    = count_ff - CNT_W'(1);
         head_ptr_in = (head_ptr_ff == PTR_W'(LIST_DEPTH - 1)) ? '0
                                                               : head_ptr_ff + PTR_W'(1);
      end
   end

   // Strict compare keeps the lower-numbered list on equal heads.
   always_comb begin
      take_own = nonempty &&
                 (!carry_in.found || ($signed(rd_data_ff) < carry_in.val));
      carry_in_next = carry_in;
      if (take_own) begin
         carry_in_next.found = 1'b1;
         carry_in_next.idx   = cell_idx;
         carry_in_next.val   = $signed(rd_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ptr_ff <= '0;
         count_ff    <= '0;
      end else begin
         head_ptr_ff <= head_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem_ff[tail_ptr] <= wr_data;
      end
      rd_data_ff <= list_mem_ff[head_ptr_ff];
      carry_ff   <= carry_in_next;
   end

   assign carry_out            = carry_ff;
   assign cell_status.nonempty = nonempty;
   assign cell_status.full     = (count_ff == CNT_W'(LIST_DEPTH));

endmodule

>>> rtl/k_way_sorted_merge_core.sv
// Top level of the k-way sorted merge core.
// Instantiates one kwm_cell per list and the controller that sequences takes.
// Depends on kwm_pkg and kwm_cell.
//
// Usage: each item on the req_ channel is either an append (req_op = 0), which
// pushes req_value onto the tail of list req_list_id, or a take (req_op = 1),
// which removes the smallest head value over all non-empty lists. Every item
// produces exactly one item on the rsp_ channel with a value and a status:
// ok, list full (the appended value was dropped, also for a list number beyond
// the last list), or all lists empty. Appends and failed takes return zero.
//
// An append is handled in the cycle it is accepted, and its result is in the
// output register in the next cycle, so appends stream at one per cycle while
// no result is stalled. A take walks a running minimum down the row of list
// cells, one cell per cycle, and then pops the winning list; the scan length is
// set by the length of the cell chain, and the input stays closed until the pop.
//
// Reset is synchronous and active high. It empties every list and the output
// register; queue contents are not cleared and are never read before written.
// When the receiver stalls, the result stays in the output register. A take
// may still be accepted and scanned meanwhile; it waits at its pop step until
// the output register frees up. An append waits at the input while a result
// is stalled, since it needs the output register in the cycle it is taken.
module k_way_sorted_merge_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic [2:0]                        req_list_id,
   input  logic signed [kwm_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [kwm_pkg::DATA_W-1:0] rsp_value_out,
   output logic [1:0]                        rsp_status
);
   import kwm_pkg::*;

   state_type                state_ff, state_in;
   logic [SCAN_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   carry_type                carry_chain [LISTS];
   cell_status_type          cell_status [LISTS];
   logic [LISTS-1:0]         wr_en;
   logic [LISTS-1:0]         pop_en;
   logic [LISTS-1:0]         target_full;

   logic                     req_accept;
   logic                     rsp_free;
   logic                     append_ok;
   logic                     append_full;
   logic                     pop_fire;
   carry_type                winner;

   // The output register can take a new result when empty or being drained.
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   // An append needs the output register at once; a take does not.
   assign req_stall  = (state_ff != ST_IDLE) ||
                       ((req_op == OP_APPEND) && !rsp_free);
   assign req_accept = req_valid && !req_stall;

   // The last cell's carry holds the overall minimum once the scan is done.
   assign winner   = carry_chain[LISTS-1];
   assign pop_fire = (state_ff == ST_POP) && rsp_free;

   // A list number beyond the row counts as a full list.
   assign append_full = (32'(req_list_id) >= 32'(LISTS)) || (|target_full);
   assign append_ok   = req_accept && (req_op == OP_APPEND) && !append_full;

   for (genvar i = 0; i < LISTS; i++) begin : g_cell
      carry_type cell_carry_in;

      assign target_full[i] = (int'(req_list_id) == i) && cell_status[i].full;
      assign wr_en[i]       = append_ok && (int'(req_list_id) == i);
      assign pop_en[i]      = pop_fire && winner.found &&
                              (winner.idx == LIST_IDX_W'(i));

      if (i == 0) begin : g_head
         assign cell_carry_in = CARRY_NONE;
      end else begin : g_body
         assign cell_carry_in = carry_chain[i-1];
      end

      kwm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (LIST_IDX_W'(i)),
         .wr_en       (wr_en[i]),
         .wr_data     (req_value),
         .pop_en      (pop_en[i]),
         .carry_in    (cell_carry_in),
         .carry_out   (carry_chain[i]),
         .cell_status (cell_status[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            scan_cnt_in = '0;
            if (req_accept) begin
               if (req_op == OP_TAKE) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = append_full ? STATUS_FULL : STATUS_OK;
               end
            end
         end
         ST_SCAN: begin
            // One cell of the chain settles per cycle.
            if (scan_cnt_ff == SCAN_W'(LISTS - 1)) begin
               state_in = ST_POP;
            end else begin
               scan_cnt_in = scan_cnt_ff + SCAN_W'(1);
            end
         end
         ST_POP: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (winner.found) begin
                  rsp_value_in  = winner.val;
                  rsp_status_in = STATUS_OK;
               end else begin
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_EMPTY;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

>>> rtl/kwm_checker.sv
// Port-level checks for the k-way sorted merge core, bound to its top level.
// Depends on kwm_pkg and on the port list of k_way_sorted_merge_core.
module kwm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_op,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [kwm_pkg::DATA_W-1:0] rsp_value_out,
   input logic [1:0]                        rsp_status
);
   import kwm_pkg::*;

   // Status codes outside the defined three never appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_EMPTY))
      else $error("result item carries an undefined status");

   // Failed appends and failed takes return a zero value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_EMPTY))
      |-> (rsp_value_out == '0))
      else $error("failed item returned a nonzero value");

   // A take keeps the input closed while the cells are scanned.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_op == OP_TAKE) |=> req_stall)
      else $error("input accepted during a take scan");

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_value_out) && $stable(rsp_status)))
      else $error("stalled result item changed");

endmodule

bind k_way_sorted_merge_core kwm_checker u_kwm_checker (.*);
